>>> rtl/saz_pkg.sv
`timescale 1ns / 1ps
// Package for the sun azimuth circular mean block.
// Holds controller states, register codes, fixed-point constants and the CORDIC angle table.
package saz_pkg;

    typedef enum logic [4:0] {
        ST_INTAKE,
        ST_DRAIN,
        ST_START,
        ST_COL,
        ST_DIV,
        ST_FOLD,
        ST_ROT,
        ST_TRIG,
        ST_ROWS,
        ST_FLUSH,
        ST_NORM0,
        ST_NORM,
        ST_VFOLD,
        ST_VEC,
        ST_SCALE,
        ST_ROUND,
        ST_OUT
    } saz_state_t;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [15:0] LUM_CR = 16'd13933;
    localparam logic [15:0] LUM_CG = 16'd46871;
    localparam logic [15:0] LUM_CB = 16'd4732;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [31:0] PI_Q29      = 32'sd1686629713;
    localparam logic signed [18:0] AZ_LIMIT    = 19'sd25736;
    localparam logic [4:0]         DIV_LAST    = 5'd30;

    localparam logic signed [64:0] SUM_MAX = {2'b00, {63{1'b1}}};
    localparam logic signed [64:0] SUM_MIN = -SUM_MAX;

    localparam logic [30:0] ATAN_TURNS [32] = '{
        31'd536870912, 31'd316933406, 31'd167458907, 31'd85004756, 31'd42667331,
        31'd21354465, 31'd10679838, 31'd5340245, 31'd2670163, 31'd1335087,
        31'd667544, 31'd333772, 31'd166886, 31'd83443, 31'd41722, 31'd20861,
        31'd10430, 31'd5215, 31'd2608, 31'd1304, 31'd652, 31'd326, 31'd163,
        31'd81, 31'd41, 31'd20, 31'd10, 31'd5, 31'd3, 31'd1, 31'd1, 31'd0
    };

    function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
                                                   logic signed [50:0] t);
        logic signed [64:0] s;
        s = {a[63], a} + {{14{t[50]}}, t};
        if (s > SUM_MAX) begin
            s = SUM_MAX;
        end
        else if (s < SUM_MIN) begin
            s = SUM_MIN;
        end
        return s[63:0];
    endfunction

endpackage

>>> rtl/sun_azimuth_circular_mean.sv
`timescale 1ns / 1ps
// Top level of the sun azimuth circular mean block: intake, luminance store and second pass.
// Depends on saz_pkg.
//
// Usage: texels enter on the in channel (in_valid / in_stall), rows top first, one beat
// per cycle while the block is in intake. Each texel of the upper half rows has its
// luminance written to the on-chip store; the peak is tracked on the fly.
// The beat with last_texel set closes the image: in_stall rises and the second pass runs.
// Per column the pass runs the divider, the CORDIC rotation and one store read per upper
// row (single read port); the final atan2 adds a normalize step, CORDIC vectoring,
// a scaling multiply and a round.
// The single result beat (azimuth, found) lands in the output register; intake reopens
// at once, and a second result waits in the last pass state while out_stall holds
// the first one.
// Reset clears counters, peak, sums and the output valid; the store is not cleared.
// Registers image_width (0x0) and image_height (0x4) sit on the APB port; the user must
// write them only while the block is idle, as the block itself does not enforce it.
module sun_azimuth_circular_mean
    import saz_pkg::*;
#(
    parameter int MAX_WIDTH     = 1024,
    parameter int MAX_HALF_ROWS = 512,
    parameter int CORDIC_STEPS  = 16
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [31:0]        red,
    input  logic [31:0]        green,
    input  logic [31:0]        blue,
    input  logic               last_texel,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] azimuth,
    output logic               found,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int DEPTH = MAX_WIDTH * MAX_HALF_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [4:0] STEP_LAST = 5'(CORDIC_STEPS - 1);

    saz_state_t state_reg, state_next;

    logic [10:0] width_reg, height_reg;
    logic [10:0] w, hr;
    logic [10:0] col_reg;
    logic [9:0]  row_reg;
    logic [31:0] peak_reg;
    logic signed [63:0] sum_cos_reg, sum_sin_reg;

    logic        s1_valid_reg, s1_store_reg, rv1_reg, pv2_reg, out_valid_reg;
    logic [AW-1:0] s1_addr_reg;
    logic [47:0] pr_reg, pg_reg, pb_reg;
    logic [49:0] lum_sum;
    logic [31:0] lum;
    logic [31:0] mem_q_reg;
    logic [31:0] luma_mem [DEPTH];
    logic [AW-1:0] rd_addr, wr_addr;

    logic [10:0] pc_reg;
    logic [9:0]  pr_cnt_reg;
    logic [10:0] rem_reg;
    logic [11:0] rem2;
    logic        div_ge;
    logic [30:0] q_reg;
    logic [4:0]  cnt_reg, i_reg;
    logic        neg_reg, flip_reg;
    logic signed [12:0] d_col;
    logic signed [33:0] x_reg, y_reg, z_reg, xs, ys, atan_v, a_fold, xf, yf;
    logic signed [17:0] co_reg, si_reg;
    logic signed [50:0] pcos_reg, psin_reg;
    logic signed [63:0] x64_reg, y64_reg;
    logic [63:0] mag_reg, ax, ay;
    logic signed [65:0] prod_reg, rsum;
    logic signed [18:0] rr;
    logic signed [15:0] res_az_reg, az_reg;
    logic        res_found_reg, found_reg;

    logic accept, store_c, cfg_wr, pass_go, load_out, row_last, col_last, sel;
    logic [10:0] coln;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign prdata   = {21'd0, paddr[2] ? height_reg : width_reg};
    assign in_stall = (state_reg != ST_INTAKE);
    assign accept   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign azimuth   = az_reg;
    assign found     = found_reg;

    assign w  = (32'(width_reg) > MAX_WIDTH) ? 11'(MAX_WIDTH) : width_reg;
    assign hr = (32'(height_reg[10:1]) > MAX_HALF_ROWS) ? 11'(MAX_HALF_ROWS)
                                                       : {1'b0, height_reg[10:1]};

    assign store_c = ({1'b0, row_reg} < hr) && (col_reg < w);
    assign coln    = col_reg + 11'd1;
    assign wr_addr = AW'(32'(row_reg) * 32'(MAX_WIDTH) + 32'(col_reg));
    assign rd_addr = AW'(32'(pr_cnt_reg) * 32'(MAX_WIDTH) + 32'(pc_reg));

    assign lum_sum = {2'b00, pr_reg} + {2'b00, pg_reg} + {2'b00, pb_reg};
    assign lum     = lum_sum[47:16];

    assign pass_go  = (peak_reg != 32'd0) && (hr != 11'd0) && (w != 11'd0);
    assign load_out = !out_valid_reg || !out_stall;
    assign row_last = ({1'b0, pr_cnt_reg} + 11'd1) == hr;
    assign col_last = (pc_reg + 11'd1) == w;
    assign sel      = {mem_q_reg, 1'b0} >= {1'b0, peak_reg};

    assign d_col  = $signed({1'b0, pc_reg, 1'b1}) - $signed({2'b00, w});
    assign rem2   = {rem_reg, 1'b0};
    assign div_ge = rem2 >= {1'b0, w};
    assign a_fold = neg_reg ? -$signed({3'b000, q_reg}) : $signed({3'b000, q_reg});

    assign xs     = x_reg >>> i_reg;
    assign ys     = y_reg >>> i_reg;
    assign atan_v = $signed({3'b000, ATAN_TURNS[i_reg]});
    assign xf     = (flip_reg ? -x_reg : x_reg) + 34'sd16384;
    assign yf     = (flip_reg ? -y_reg : y_reg) + 34'sd16384;

    assign ax = sum_cos_reg[63] ? 64'(-sum_cos_reg) : 64'(sum_cos_reg);
    assign ay = sum_sin_reg[63] ? 64'(-sum_sin_reg) : 64'(sum_sin_reg);

    assign rsum = prod_reg + 66'sh400000000000;
    assign rr   = rsum[65:47];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INTAKE: if (accept && last_texel) state_next = ST_DRAIN;
            ST_DRAIN:  state_next = ST_START;
            ST_START:  state_next = pass_go ? ST_COL : ST_OUT;
            ST_COL:    state_next = ST_DIV;
            ST_DIV:    if (cnt_reg == DIV_LAST) state_next = ST_FOLD;
            ST_FOLD:   state_next = ST_ROT;
            ST_ROT:    if (i_reg == STEP_LAST) state_next = ST_TRIG;
            ST_TRIG:   state_next = ST_ROWS;
            ST_ROWS:   if (row_last) state_next = ST_FLUSH;
            ST_FLUSH:
            begin
                if (!rv1_reg && !pv2_reg) state_next = col_last ? ST_NORM0 : ST_COL;
            end
            ST_NORM0:  state_next = ST_NORM;
            ST_NORM:
            begin
                if (mag_reg == 64'd0) state_next = ST_OUT;
                else if (mag_reg[63:30] == 34'd0) state_next = ST_VFOLD;
            end
            ST_VFOLD:  state_next = ST_VEC;
            ST_VEC:    if (i_reg == STEP_LAST) state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_ROUND;
            ST_ROUND:  state_next = ST_OUT;
            ST_OUT:    if (load_out) state_next = ST_INTAKE;
            default:   state_next = ST_INTAKE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INTAKE;
            width_reg     <= 11'd1024;
            height_reg    <= 11'd512;
            col_reg       <= '0;
            row_reg       <= '0;
            peak_reg      <= '0;
            sum_cos_reg   <= '0;
            sum_sin_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            rv1_reg       <= 1'b0;
            pv2_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr)
            begin
                unique case (paddr[2])
                    REG_WIDTH:  width_reg  <= pwdata[10:0];
                    REG_HEIGHT: height_reg <= pwdata[10:0];
                    default:    width_reg  <= width_reg;
                endcase
            end
            s1_valid_reg <= accept;
            if (accept)
            begin
                if (coln >= w)
                begin
                    col_reg <= '0;
                    if (row_reg != 10'd1023) row_reg <= row_reg + 10'd1;
                end
                else
                begin
                    col_reg <= coln;
                end
            end
            if (s1_valid_reg && s1_store_reg && (lum > peak_reg)) peak_reg <= lum;
            rv1_reg <= (state_reg == ST_ROWS);
            pv2_reg <= rv1_reg && sel;
            if (pv2_reg)
            begin
                sum_cos_reg <= sat_add(sum_cos_reg, pcos_reg >>> 4);
                sum_sin_reg <= sat_add(sum_sin_reg, psin_reg >>> 4);
            end
            out_valid_reg <= (state_reg == ST_OUT && load_out) || (out_valid_reg && out_stall);
            if (state_reg == ST_OUT && load_out)
            begin
                peak_reg      <= '0;
                col_reg       <= '0;
                row_reg       <= '0;
                sum_cos_reg   <= '0;
                sum_sin_reg   <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_store_reg) luma_mem[s1_addr_reg] <= lum;
        mem_q_reg <= luma_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_store_reg <= store_c;
            s1_addr_reg  <= wr_addr;
            pr_reg       <= red * LUM_CR;
            pg_reg       <= green * LUM_CG;
            pb_reg       <= blue * LUM_CB;
        end
        if (rv1_reg)
        begin
            pcos_reg <= $signed({1'b0, mem_q_reg}) * co_reg;
            psin_reg <= $signed({1'b0, mem_q_reg}) * si_reg;
        end
        if (state_reg == ST_OUT && load_out)
        begin
            az_reg    <= res_az_reg;
            found_reg <= res_found_reg;
        end
        unique case (state_reg)
            ST_START:
            begin
                pc_reg        <= '0;
                res_az_reg    <= '0;
                res_found_reg <= 1'b0;
            end
            ST_COL:
            begin
                neg_reg <= d_col[12];
                rem_reg <= d_col[12] ? 11'(-d_col) : 11'(d_col);
                q_reg   <= '0;
                cnt_reg <= '0;
            end
            ST_DIV:
            begin
                rem_reg <= div_ge ? 11'(rem2 - {1'b0, w}) : rem2[10:0];
                q_reg   <= {q_reg[29:0], div_ge};
                cnt_reg <= cnt_reg + 5'd1;
            end
            ST_FOLD:
            begin
                x_reg <= CORDIC_GAIN;
                y_reg <= '0;
                i_reg <= '0;
                if (a_fold > 34'sd1073741824)
                begin
                    z_reg    <= a_fold - 34'sd2147483648;
                    flip_reg <= 1'b1;
                end
                else if (a_fold < -34'sd1073741824)
                begin
                    z_reg    <= a_fold + 34'sd2147483648;
                    flip_reg <= 1'b1;
                end
                else
                begin
                    z_reg    <= a_fold;
                    flip_reg <= 1'b0;
                end
            end
            ST_ROT:
            begin
                if (!z_reg[33])
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - atan_v;
                end
                else
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + atan_v;
                end
                i_reg <= i_reg + 5'd1;
            end
            ST_TRIG:
            begin
                co_reg     <= xf[32:15];
                si_reg     <= yf[32:15];
                pr_cnt_reg <= '0;
            end
            ST_ROWS:
            begin
                pr_cnt_reg <= pr_cnt_reg + 10'd1;
            end
            ST_FLUSH:
            begin
                if (!rv1_reg && !pv2_reg && !col_last) pc_reg <= pc_reg + 11'd1;
            end
            ST_NORM0:
            begin
                x64_reg       <= sum_cos_reg;
                y64_reg       <= sum_sin_reg;
                mag_reg       <= (ax > ay) ? ax : ay;
                res_found_reg <= 1'b1;
            end
            ST_NORM:
            begin
                if (mag_reg[63:30] != 34'd0)
                begin
                    x64_reg <= x64_reg >>> 1;
                    y64_reg <= y64_reg >>> 1;
                    mag_reg <= mag_reg >> 1;
                end
            end
            ST_VFOLD:
            begin
                i_reg <= '0;
                if (x64_reg[63])
                begin
                    x_reg <= -x64_reg[33:0];
                    y_reg <= -y64_reg[33:0];
                    z_reg <= y64_reg[63] ? -34'sd2147483648 : 34'sd2147483648;
                end
                else
                begin
                    x_reg <= x64_reg[33:0];
                    y_reg <= y64_reg[33:0];
                    z_reg <= '0;
                end
            end
            ST_VEC:
            begin
                if (!y_reg[33])
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + atan_v;
                end
                else
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - atan_v;
                end
                i_reg <= i_reg + 5'd1;
            end
            ST_SCALE:
            begin
                prod_reg <= z_reg * PI_Q29;
            end
            ST_ROUND:
            begin
                if (rr > AZ_LIMIT) res_az_reg <= AZ_LIMIT[15:0];
                else if (rr < -AZ_LIMIT) res_az_reg <= 16'(-AZ_LIMIT);
                else res_az_reg <= rr[15:0];
            end
            default:
            begin
                res_az_reg <= res_az_reg;
            end
        endcase
    end

endmodule

>>> rtl/saz_checker.sv
`timescale 1ns / 1ps
// Port checker for the sun azimuth circular mean block, bound to the top level.
// Depends on saz_pkg and sun_azimuth_circular_mean.
module saz_port_checks
    import saz_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               last_texel,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] azimuth,
    input logic               found
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(azimuth) && $stable(found))
        else $error("result beat changed while stalled");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> azimuth == 16'sd0)
        else $error("azimuth nonzero without found");

    a_az_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (azimuth <= $signed(AZ_LIMIT[15:0])) && (azimuth >= 16'(-AZ_LIMIT)))
        else $error("azimuth out of range");

    a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_texel |=> in_stall)
        else $error("intake open right after last texel");

endmodule

bind sun_azimuth_circular_mean saz_port_checks u_saz_port_checks (.*);

>>> dv/saz_checker.sv
`timescale 1ns / 1ps
// Checker for the sun azimuth circular mean block: watches the APB port and both channels.
// Predicts azimuth and found for each image and compares them with the result beats.
// Depends on saz_pkg for the register codes and the CORDIC constants.
module saz_checker
    import saz_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [31:0]        red,
    input  logic [31:0]        green,
    input  logic [31:0]        blue,
    input  logic               last_texel,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [15:0] azimuth,
    input  logic               found,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 errors,
    output int                 pending,
    output int                 results_seen
);

    localparam int STEPS     = 16;
    localparam int WIDTH_CAP = 1024;
    localparam int ROWS_CAP  = 512;

    logic [10:0]       width_reg;
    logic [10:0]       height_reg;
    int unsigned       luma_mem [int unsigned];
    int unsigned       peak;
    int unsigned       col;
    int unsigned       row;
    logic signed [15:0] az_queue [$];
    logic              found_queue [$];

    function automatic void column_trig(input int unsigned c, input int unsigned w,
                                        output longint co, output longint si);
        longint d, a, x, y, xs, ys;
        longint unsigned m;
        bit flip;
        d = 2 * longint'(c) + 1 - longint'(w);
        m = (d < 0) ? -d : d;
        a = longint'((m << 31) / w);
        x = longint'(CORDIC_GAIN);
        y = 0;
        flip = 0;
        if (d < 0) a = -a;
        if (a > (longint'(1) << 30)) begin
            a -= longint'(1) << 31;
            flip = 1;
        end
        else if (a < -(longint'(1) << 30)) begin
            a += longint'(1) << 31;
            flip = 1;
        end
        for (int i = 0; i < STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (a >= 0) begin
                x -= ys; y += xs; a -= longint'(ATAN_TURNS[i]);
            end
            else begin
                x += ys; y -= xs; a += longint'(ATAN_TURNS[i]);
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        co = (x + (longint'(1) << 14)) >>> 15;
        si = (y + (longint'(1) << 14)) >>> 15;
    endfunction

    function automatic longint add_clamped(input longint a, input longint b);
        longint lim;
        lim = 64'h7FFF_FFFF_FFFF_FFFF;
        if (b > 0 && a > lim - b) return lim;
        if (b < 0 && a < -lim - b) return -lim;
        return a + b;
    endfunction

    function automatic longint azimuth_of(input longint sy, input longint sx);
        longint unsigned mx, my, mag;
        longint x, y, z, xs, ys, r;
        int s;
        mx = (sx < 0) ? -sx : sx;
        my = (sy < 0) ? -sy : sy;
        mag = (mx > my) ? mx : my;
        s = 0;
        z = 0;
        if (mag == 0) return 0;
        while ((mag >> s) >= (longint'(1) << 30)) s++;
        x = sx >>> s;
        y = sy >>> s;
        if (x < 0) begin
            z = (y >= 0) ? (longint'(1) << 31) : -(longint'(1) << 31);
            x = -x; y = -y;
        end
        for (int i = 0; i < STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += longint'(ATAN_TURNS[i]);
            end
            else begin
                x -= ys; y += xs; z -= longint'(ATAN_TURNS[i]);
            end
        end
        r = (z * longint'(PI_Q29) + (longint'(1) << 46)) >>> 47;
        if (r > longint'(AZ_LIMIT)) r = longint'(AZ_LIMIT);
        if (r < -longint'(AZ_LIMIT)) r = -longint'(AZ_LIMIT);
        return r;
    endfunction

    task automatic take_texel();
        int unsigned w, hr, lum, v;
        longint unsigned acc;
        longint sc, ss, co, si, az;
        logic fnd;
        w = (width_reg > WIDTH_CAP) ? WIDTH_CAP : width_reg;
        hr = height_reg / 2;
        if (hr > ROWS_CAP) hr = ROWS_CAP;
        acc = 64'd13933 * red + 64'd46871 * green + 64'd4732 * blue;
        lum = acc[47:16];
        if (row < hr && col < w) begin
            luma_mem[row * WIDTH_CAP + col] = lum;
            if (lum > peak) peak = lum;
        end
        col++;
        if (col >= w) begin
            col = 0;
            if (row < 1023) row++;
        end
        if (!last_texel) return;
        az = 0;
        fnd = 0;
        sc = 0;
        ss = 0;
        if (peak > 0 && hr > 0 && w > 0) begin
            fnd = 1;
            for (int unsigned r = 0; r < hr; r++) begin
                for (int unsigned c = 0; c < w; c++) begin
                    v = luma_mem.exists(r * WIDTH_CAP + c) ? luma_mem[r * WIDTH_CAP + c] : 0;
                    if (2 * longint'(v) < longint'(peak)) continue;
                    column_trig(c, w, co, si);
                    sc = add_clamped(sc, (longint'(v) * co) >>> 4);
                    ss = add_clamped(ss, (longint'(v) * si) >>> 4);
                end
            end
            az = azimuth_of(ss, sc);
        end
        az_queue.push_back(az[15:0]);
        found_queue.push_back(fnd);
        peak = 0;
        col = 0;
        row = 0;
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            width_reg = 11'd1024;
            height_reg = 11'd512;
            peak = 0;
            col = 0;
            row = 0;
            errors = 0;
            results_seen = 0;
            az_queue.delete();
            found_queue.delete();
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_HEIGHT) height_reg = pwdata[10:0];
                else width_reg = pwdata[10:0];
            end
            if (in_valid && !in_stall) take_texel();
            if (out_valid && !out_stall) begin
                results_seen++;
                if (az_queue.size() == 0) begin
                    errors++;
                    $display("%0t: result beat with none expected: azimuth %0d found %0b",
                             $time, azimuth, found);
                end
                else begin
                    if (azimuth !== az_queue[0]) begin
                        errors++;
                        $display("%0t: azimuth mismatch: expected %0d actual %0d",
                                 $time, az_queue[0], azimuth);
                    end
                    if (found !== found_queue[0]) begin
                        errors++;
                        $display("%0t: found mismatch: expected %0b actual %0b",
                                 $time, found_queue[0], found);
                    end
                    void'(az_queue.pop_front());
                    void'(found_queue.pop_front());
                end
            end
        end
        pending = az_queue.size();
    end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Top of the sun azimuth circular mean testbench: clock, reset, APB writes and texel stimulus.
// Depends on saz_pkg, sun_azimuth_circular_mean and saz_checker.
module testbench;
    import saz_pkg::*;

    localparam int IDLE_LIMIT = 400000;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               in_valid = 0;
    logic               in_stall;
    logic [31:0]        red = 0;
    logic [31:0]        green = 0;
    logic [31:0]        blue = 0;
    logic               last_texel = 0;
    logic               out_valid;
    logic               out_stall = 0;
    logic signed [15:0] azimuth;
    logic               found;
    logic               psel = 0;
    logic               penable = 0;
    logic               pwrite = 0;
    logic [2:0]         paddr = 0;
    logic [31:0]        pwdata = 0;
    logic [31:0]        prdata;
    logic               pready;

    int errors, pending, results_seen;
    int texels = 0;
    int images = 0;
    int gap_max = 8;
    int stall_left = 0;
    int idle_cycles = 0;
    logic out_took = 0;
    logic out_drawn = 0;

    sun_azimuth_circular_mean dut (.*);

    saz_checker checker_i (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .red(red),
        .green(green), .blue(blue), .last_texel(last_texel), .out_valid(out_valid),
        .out_stall(out_stall), .azimuth(azimuth), .found(found), .psel(psel),
        .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .pready(pready), .errors(errors), .pending(pending), .results_seen(results_seen)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        out_took <= out_valid && !out_stall;
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
            $display("testbench: FAIL");
            $finish;
        end
    end

    // hold stall for a drawn number of cycles on each result beat
    always @(negedge clk)
    begin
        if (out_took)
        begin
            out_drawn = 0;
        end
        if (out_valid && !out_drawn)
        begin
            stall_left = (gap_max == 0) ? 0 : $urandom_range(0, 8);
            out_drawn = 1;
        end
        if (stall_left > 0)
        begin
            out_stall <= 1;
            stall_left--;
        end
        else
        begin
            out_stall <= 0;
        end
    end

    task automatic reg_write(input logic reg_code, input logic [31:0] value);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {reg_code, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    task automatic send_texel(input logic [31:0] r, input logic [31:0] g,
                              input logic [31:0] b, input logic last);
        int gap;
        gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        red <= r;
        green <= g;
        blue <= b;
        last_texel <= last;
        in_valid <= 1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        texels++;
    endtask

    function automatic logic [31:0] channel(input int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 1023);
            2: return 0;
            3: return ($urandom_range(0, 7) == 0) ? $urandom : 32'd0;
            4: return 32'hFFFF_FFFF;
            default: return 32'h0001_0000;
        endcase
    endfunction

    task automatic settle();
        in_valid <= 0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // write both registers, then send a full upper region plus extra texels
    task automatic run_image(input int w, input int h, input int extra, input int mode);
        int ew, hr, n;
        reg_write(REG_WIDTH, w);
        reg_write(REG_HEIGHT, h);
        ew = (w > 1024) ? 1024 : w;
        hr = h / 2;
        if (hr > 512) hr = 512;
        n = ew * hr + extra;
        if (n < 1) n = 1;
        for (int i = 0; i < n; i++)
        begin
            send_texel(channel(mode), channel(mode), channel(mode), i == n - 1);
        end
        images++;
        settle();
    endtask

    initial
    begin
        int w, h, m;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        run_image(1, 2, 0, 4);
        run_image(3, 2, 0, 2);
        run_image(2, 2, 0, 5);
        run_image(4, 3, 1, 3);
        run_image(2047, 1, 2, 0);
        run_image(0, 4, 2, 0);
        run_image(5, 0, 1, 0);
        run_image(3, 4, 3, 1);
        run_image(1, 2047, 0, 0);
        run_image(1024, 1, 1, 0);

        while (texels < 1350 || results_seen < 60)
        begin
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            h = $urandom_range(0, 9);
            m = $urandom_range(0, 9);
            if (m > 5) m = 0;
            run_image(w, h, $urandom_range(0, w + 3), m);
        end

        repeat (50) @(posedge clk);
        $display("Ran %0d images, %0d texels, %0d result beats.", images, texels,
                 results_seen);
        if (errors == 0 && pending == 0)
        begin
            $display("testbench: PASS");
        end
        else
        begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/saz_pkg.sv
rtl/sun_azimuth_circular_mean.sv
rtl/saz_checker.sv
dv/saz_checker.sv
dv/testbench.sv
